// ===== hw/rtl/ssph_pkg.sv =====
// Shared types, constants and widths for the spectrum smoothing and peak hold core.
package ssph_pkg;

    // bin store geometry
    localparam int BINS      = 1024;
    localparam int BIN_W     = $clog2(BINS);

    // field widths
    localparam int BIN_IDX_W = 10;
    localparam int LEVEL_W   = 16;
    localparam int AGE_W     = 16;
    localparam int ALPHA_W   = 16;
    localparam int HOLD_W    = 16;
    localparam int DECAY_W   = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // -120 dB in Q8.8
    localparam logic signed [LEVEL_W-1:0] FLOOR_DB = -16'sd30720;
    localparam logic [AGE_W-1:0]          AGE_MAX  = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;

    // register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd45875;
    localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd43;
    localparam logic [DECAY_W-1:0] DECAY_RST = 15'd89;

    typedef struct packed {
        logic [AGE_W-1:0]          age;
        logic signed [LEVEL_W-1:0] peak;
        logic signed [LEVEL_W-1:0] smoothed;
    } ssph_entry_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [HOLD_W-1:0]  hold;
        logic [DECAY_W-1:0] decay;
    } ssph_cfg_t;

    localparam ssph_entry_t ENTRY_RST = '{age: '0, peak: FLOOR_DB, smoothed: FLOOR_DB};

endpackage

// ===== hw/rtl/spectrum_smoothing_peak_hold_core.sv =====
// Top level of the spectrum smoothing and peak hold core: bin store, pipeline and config.
//
// One word in per clock unless the output stalls, one word out per word in, in order. Each
// input word carries a bin index and a level in dB (signed Q8.8); the core keeps the smoothed
// level, held peak and hold age of every bin in a single 48-bit wide, 1024-deep synchronous
// store and returns the bin's new smoothed level and peak. Sustained rate is one word per cycle
// while m_tready stays high, set by the store's single read and single write port: a word is
// read on acceptance, updated and written back as the result enters the output register,
// which drives m_tvalid. Words for the same bin may follow back to back; the value written on
// the previous edge is forwarded. After reset the store is cleared, with s_tready held low
// meanwhile; config writes are taken throughout. Bin indexes wrap modulo the store depth for
// addressing; out_bin still returns the index as given. Config is to be written by the user only
// while the core is idle; the core does not enforce it. Register indexes: 0 smoothing alpha
// (Q0.16, attack uses half), 1 hold frames, 2 decay step (Q8.8 dB); other indexes are ignored.
module spectrum_smoothing_peak_hold_core
    import ssph_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] bin_index, [25:10] level_db, rest zero

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] out_bin, [25:10] smoothed_db,
                                             // [41:26] peak_db, rest zero

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    // bin store
    ssph_entry_t mem [BINS];

    ssph_cfg_t                 cfg_reg;
    logic [BIN_W:0]            clr_cnt_reg;
    logic [BIN_W:0]            clr_cnt_next;
    logic                      clr_done;

    // stage 1: read data back from the store, update computed
    logic                      s1_valid_reg;
    logic [BIN_IDX_W-1:0]      s1_bin_reg;
    logic signed [LEVEL_W-1:0] s1_level_reg;
    ssph_entry_t               rd_entry_reg;

    // last write, for forwarding past the read-first store
    logic                      wb_valid_reg;
    logic [BIN_W-1:0]          wb_addr_reg;
    ssph_entry_t               wb_entry_reg;

    // output register
    logic                      m_valid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    logic                      adv;
    logic                      s_accept;
    logic [BIN_IDX_W-1:0]      in_bin;
    logic [BIN_W-1:0]          in_addr;
    logic [BIN_W-1:0]          s1_addr;
    logic                      fwd;
    ssph_entry_t               old_entry;
    ssph_entry_t               new_entry;

    logic                      mem_we;
    logic [BIN_W-1:0]          mem_waddr;
    ssph_entry_t               mem_wdata;

    // whole pipeline moves together whenever the output register can take a word
    assign adv       = !m_valid_reg || m_tready;
    assign clr_done  = clr_cnt_reg == (BIN_W+1)'(BINS);
    assign s_tready  = adv && clr_done;
    assign s_accept  = s_tvalid && s_tready;

    assign in_bin    = s_tdata[BIN_IDX_W-1:0];
    assign in_addr   = BIN_W'(in_bin);
    assign s1_addr   = BIN_W'(s1_bin_reg);

    // previous word for the same bin was written on the edge that read this one
    assign fwd       = wb_valid_reg && (wb_addr_reg == s1_addr);
    assign old_entry = fwd ? wb_entry_reg : rd_entry_reg;

    ssph_bin_update u_update (
        .level_db  (s1_level_reg),
        .old_entry (old_entry),
        .cfg       (cfg_reg),
        .new_entry (new_entry)
    );

    // clearing pass owns the write port until done
    always_comb begin
        clr_cnt_next = clr_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;
        if (clr_done) begin
            mem_we    = adv && s1_valid_reg;
            mem_waddr = s1_addr;
            mem_wdata = new_entry;
        end else begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[BIN_W-1:0];
            mem_wdata = ENTRY_RST;
        end
    end

    // store: one write, one registered read, read-first
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_entry_reg <= mem[in_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            if (adv) begin
                s1_valid_reg <= s_accept;
                wb_valid_reg <= s1_valid_reg;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha <= ALPHA_RST;
            cfg_reg.hold  <= HOLD_RST;
            cfg_reg.decay <= DECAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALPHA: begin
                    cfg_reg.alpha <= cfg_wdata;
                end
                REG_HOLD: begin
                    cfg_reg.hold <= cfg_wdata;
                end
                REG_DECAY: begin
                    cfg_reg.decay <= cfg_wdata[DECAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_bin_reg   <= in_bin;
            s1_level_reg <= $signed(s_tdata[BIN_IDX_W+LEVEL_W-1:BIN_IDX_W]);
        end
        if (adv) begin
            wb_addr_reg  <= s1_addr;
            wb_entry_reg <= new_entry;
            m_tdata_reg  <= {6'b0, new_entry.peak, new_entry.smoothed, s1_bin_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/ssph_bin_update.sv =====
// Per-bin update: asymmetric one-pole smoothing, peak hold with age and floored decay.
module ssph_bin_update
    import ssph_pkg::*;
(
    input  logic signed [LEVEL_W-1:0] level_db,
    input  ssph_entry_t               old_entry,
    input  ssph_cfg_t                 cfg,
    output ssph_entry_t               new_entry
);

    logic                      attack;
    logic [ALPHA_W-1:0]        coef;
    logic signed [LEVEL_W:0]   diff;
    logic signed [2*LEVEL_W+1:0] prod;
    logic signed [2*LEVEL_W+2:0] acc;
    logic signed [LEVEL_W-1:0] sm;
    logic [AGE_W-1:0]          age_inc;
    logic                      do_decay;
    logic signed [LEVEL_W:0]   pk_dec;

    // new = cur + (old - cur) * c / 2^16, rounded half up
    always_comb begin
        attack = level_db > old_entry.smoothed;
        coef   = attack ? {1'b0, cfg.alpha[ALPHA_W-1:1]} : cfg.alpha;
        diff   = $signed({old_entry.smoothed[LEVEL_W-1], old_entry.smoothed})
               - $signed({level_db[LEVEL_W-1], level_db});
        prod   = diff * $signed({1'b0, coef});
        acc    = $signed({{3{level_db[LEVEL_W-1]}}, level_db, 16'h8000})
               + $signed({prod[2*LEVEL_W+1], prod});
        sm     = acc[2*LEVEL_W-1:LEVEL_W];
    end

    always_comb begin
        age_inc  = (old_entry.age == AGE_MAX) ? old_entry.age : old_entry.age + 16'd1;
        do_decay = age_inc > cfg.hold;
        pk_dec   = $signed({old_entry.peak[LEVEL_W-1], old_entry.peak})
                 - $signed(do_decay ? {2'b00, cfg.decay} : 17'd0);

        new_entry.smoothed = sm;
        if (sm >= old_entry.peak) begin
            new_entry.peak = sm;
            new_entry.age  = '0;
        end else begin
            new_entry.age  = age_inc;
            if (pk_dec < $signed({FLOOR_DB[LEVEL_W-1], FLOOR_DB})) begin
                new_entry.peak = FLOOR_DB;
            end else begin
                new_entry.peak = pk_dec[LEVEL_W-1:0];
            end
        end
    end

endmodule
